[hdl/ffa_pkg.sv]
`timescale 1ns / 1ps

package ffa_pkg;

  // Byte positions inside the pool are carried with headroom for pos + 4 + size.
  localparam int POS_W = 17;
  localparam int CFG_W = 15;
  localparam int HDR_W = 16;
  localparam int CNT_W = 13;

  localparam logic [1:0] CMD_ALLOC  = 2'd0;
  localparam logic [1:0] CMD_FREE   = 2'd1;
  localparam logic [1:0] CMD_REPORT = 2'd2;

  localparam logic [1:0] MARK_FREE = 2'd1;
  localparam logic [1:0] MARK_BUSY = 2'd2;

  localparam logic [15:0] LOW_MARK_INIT = 16'hFFFF;

  typedef enum logic [2:0] {
    ST_OK,
    ST_ZERO,
    ST_TOO_LARGE,
    ST_NO_FIT,
    ST_NOT_BLOCK,
    ST_NOT_BUSY,
    ST_OUTSIDE
  } status_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_A_WALK,
    S_A_MARK,
    S_F_WALK,
    S_CO_START,
    S_CO_HEAD,
    S_CO_WALK,
    S_ST_START,
    S_ST_WALK,
    S_DONE
  } state_t;

  typedef struct packed {
    status_t      status;
    logic [15:0]  addr;
    logic [14:0]  free_bytes;
    logic [14:0]  largest_free;
    logic [12:0]  free_blocks;
    logic [12:0]  busy_blocks;
    logic [15:0]  min_largest_free;
    logic [15:0]  min_free_total;
    logic [12:0]  peak_blocks;
    logic [12:0]  max_busy;
    logic [15:0]  min_request;
    logic [15:0]  max_request;
  } res_t;

endpackage

[hdl/ffa_if.sv]
`timescale 1ns / 1ps

interface ffa_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [15:0] req_bytes;
  logic [15:0] block_addr;
  modport source (output valid, cmd, req_bytes, block_addr, input ready);
  modport sink (input valid, cmd, req_bytes, block_addr, output ready);
endinterface

interface ffa_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] addr;
  logic [14:0] free_bytes;
  logic [14:0] largest_free;
  logic [12:0] free_blocks;
  logic [12:0] busy_blocks;
  logic [15:0] min_largest_free;
  logic [15:0] min_free_total;
  logic [12:0] peak_blocks;
  logic [12:0] max_busy;
  logic [15:0] min_request;
  logic [15:0] max_request;
  modport source (output valid, status, addr, free_bytes, largest_free, free_blocks,
                  busy_blocks, min_largest_free, min_free_total, peak_blocks, max_busy,
                  min_request, max_request, input ready);
  modport sink (input valid, status, addr, free_bytes, largest_free, free_blocks,
                busy_blocks, min_largest_free, min_free_total, peak_blocks, max_busy,
                min_request, max_request, output ready);
endinterface

interface ffa_cfg_if;
  logic        valid;
  logic        ready;
  logic [14:0] pool_bytes;
  modport source (output valid, pool_bytes, input ready);
  modport sink (input valid, pool_bytes, output ready);
endinterface

[hdl/ffa_hdr_ram.sv]
`timescale 1ns / 1ps

module ffa_hdr_ram import ffa_pkg::*; #(
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [HDR_W-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [HDR_W-1:0]         rdata
);

  logic [HDR_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/ffa_walk.sv]
`timescale 1ns / 1ps

module ffa_walk import ffa_pkg::*; #(
  parameter int POOL_WORDS = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [CFG_W-1:0]              pool,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    cmd,
  input  logic [15:0]                   req_bytes,
  input  logic [15:0]                   block_addr,
  input  logic                          out_free,
  output logic                          res_load,
  output res_t                          res,
  output logic                          mem_we,
  output logic [$clog2(POOL_WORDS)-1:0] mem_waddr,
  output logic [HDR_W-1:0]              mem_wdata,
  output logic [$clog2(POOL_WORDS)-1:0] mem_raddr,
  input  logic [HDR_W-1:0]              mem_rdata
);

  localparam int WADDR = $clog2(POOL_WORDS);

  state_t state, state_next;
  logic [1:0]       cmd_q, cmd_q_next;
  logic [15:0]      baddr_q, baddr_q_next;
  logic [POS_W-1:0] rsz_q, rsz_q_next;
  logic [POS_W-1:0] pos, pos_next, npos, npos_next;
  logic [HDR_W-1:0] hcur, hcur_next;
  status_t          status_q, status_q_next;
  logic [15:0]      addr_q, addr_q_next;
  logic             changed, changed_next;
  logic [15:0]      fbytes, fbytes_next, largest, largest_next;
  logic [CNT_W-1:0] nfree, nfree_next, nbusy, nbusy_next;
  logic [15:0]      ll_mark, ll_mark_next, lf_mark, lf_mark_next;
  logic [CNT_W-1:0] hb_mark, hb_mark_next, hbusy_mark, hbusy_mark_next;
  logic [15:0]      lreq_mark, lreq_mark_next, hreq_mark, hreq_mark_next;

  logic [POS_W-1:0] pool_w, rsz_in, hsz, step, merged, merge_step, keep_step, wpos, rd_pos;
  logic [1:0]       mark;
  logic             step_end;
  logic [CNT_W:0]   nblocks;
  logic [15:0]      ll_upd, lf_upd;
  logic [CNT_W-1:0] hb_upd, hbusy_upd;

  assign pool_w     = {2'b00, pool};
  assign rsz_in     = ({1'b0, req_bytes} + 17'd3) & ~17'd3;
  assign hsz        = {1'b0, mem_rdata & 16'hFFFC};
  assign mark       = mem_rdata[1:0];
  assign step       = pos + 17'd4 + hsz;
  assign step_end   = step >= pool_w;
  assign merged     = {1'b0, hcur & 16'hFFFC} + hsz + 17'd4;
  assign merge_step = pos + 17'd4 + merged;
  assign keep_step  = npos + 17'd4 + hsz;

  assign mem_waddr = wpos[WADDR+1:2];
  assign mem_raddr = rd_pos[WADDR+1:2];

  // Watermarks as they stand once this command's statistics are in.
  assign nblocks   = {1'b0, nfree} + {1'b0, nbusy};
  assign ll_upd    = (changed && largest < ll_mark) ? largest : ll_mark;
  assign lf_upd    = (changed && fbytes < lf_mark) ? fbytes : lf_mark;
  assign hb_upd    = (changed && nblocks > {1'b0, hb_mark}) ? nblocks[CNT_W-1:0] : hb_mark;
  assign hbusy_upd = (changed && nbusy > hbusy_mark) ? nbusy : hbusy_mark;

  always_comb begin
    res.status           = status_q;
    res.addr             = addr_q;
    res.free_bytes       = fbytes[14:0];
    res.largest_free     = largest[14:0];
    res.free_blocks      = nfree;
    res.busy_blocks      = nbusy;
    res.min_largest_free = ll_upd;
    res.min_free_total   = lf_upd;
    res.peak_blocks      = hb_upd;
    res.max_busy         = hbusy_upd;
    res.min_request      = lreq_mark;
    res.max_request      = hreq_mark;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      ll_mark    <= LOW_MARK_INIT;
      lf_mark    <= LOW_MARK_INIT;
      hb_mark    <= '0;
      hbusy_mark <= '0;
      lreq_mark  <= LOW_MARK_INIT;
      hreq_mark  <= '0;
    end else begin
      state      <= state_next;
      ll_mark    <= ll_mark_next;
      lf_mark    <= lf_mark_next;
      hb_mark    <= hb_mark_next;
      hbusy_mark <= hbusy_mark_next;
      lreq_mark  <= lreq_mark_next;
      hreq_mark  <= hreq_mark_next;
    end
    cmd_q    <= cmd_q_next;
    baddr_q  <= baddr_q_next;
    rsz_q    <= rsz_q_next;
    pos      <= pos_next;
    npos     <= npos_next;
    hcur     <= hcur_next;
    status_q <= status_q_next;
    addr_q   <= addr_q_next;
    changed  <= changed_next;
    fbytes   <= fbytes_next;
    largest  <= largest_next;
    nfree    <= nfree_next;
    nbusy    <= nbusy_next;
  end

  always_comb begin
    state_next      = state;
    cmd_q_next      = cmd_q;
    baddr_q_next    = baddr_q;
    rsz_q_next      = rsz_q;
    pos_next        = pos;
    npos_next       = npos;
    hcur_next       = hcur;
    status_q_next   = status_q;
    addr_q_next     = addr_q;
    changed_next    = changed;
    fbytes_next     = fbytes;
    largest_next    = largest;
    nfree_next      = nfree;
    nbusy_next      = nbusy;
    ll_mark_next    = ll_mark;
    lf_mark_next    = lf_mark;
    hb_mark_next    = hb_mark;
    hbusy_mark_next = hbusy_mark;
    lreq_mark_next  = lreq_mark;
    hreq_mark_next  = hreq_mark;
    in_ready        = 1'b0;
    res_load        = 1'b0;
    mem_we          = 1'b0;
    wpos            = pos;
    mem_wdata       = '0;
    rd_pos          = step;

    unique case (state)
      S_INIT: begin
        mem_we     = 1'b1;
        wpos       = '0;
        mem_wdata  = 16'(pool_w - 17'd4) | {14'd0, MARK_FREE};
        state_next = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        rd_pos   = '0;
        if (in_valid) begin
          cmd_q_next    = cmd;
          baddr_q_next  = block_addr;
          rsz_q_next    = rsz_in;
          pos_next      = '0;
          addr_q_next   = '0;
          changed_next  = 1'b0;
          fbytes_next   = '0;
          largest_next  = '0;
          nfree_next    = '0;
          nbusy_next    = '0;
          status_q_next = ST_OK;
          state_next    = S_ST_WALK;
          unique case (cmd)
            CMD_ALLOC: begin
              if (req_bytes == 16'd0) begin
                status_q_next = ST_ZERO;
              end else if (rsz_in > pool_w) begin
                status_q_next = ST_TOO_LARGE;
              end else begin
                if (req_bytes < lreq_mark) lreq_mark_next = req_bytes;
                if (req_bytes > hreq_mark) hreq_mark_next = req_bytes;
                status_q_next = ST_NO_FIT;
                state_next    = S_A_WALK;
              end
            end
            CMD_FREE: begin
              if ({1'b0, block_addr} >= pool_w) begin
                status_q_next = ST_OUTSIDE;
              end else begin
                status_q_next = ST_NOT_BLOCK;
                state_next    = S_F_WALK;
              end
            end
            default: begin
              status_q_next = ST_OK;
            end
          endcase
        end
      end
      S_A_WALK: begin
        if (mark == MARK_FREE && hsz >= rsz_q) begin
          addr_q_next   = 16'(pos + 17'd4);
          status_q_next = ST_OK;
          changed_next  = 1'b1;
          mem_we        = 1'b1;
          if (hsz - rsz_q >= 17'd8) begin
            // Carve the tail off as a new free block, then mark the head busy.
            wpos       = pos + 17'd4 + rsz_q;
            mem_wdata  = 16'(hsz - rsz_q - 17'd4) | {14'd0, MARK_FREE};
            state_next = S_A_MARK;
          end else begin
            mem_wdata  = {mem_rdata[15:2], MARK_BUSY};
            state_next = S_ST_START;
          end
        end else if (step_end) begin
          state_next = S_ST_START;
        end else begin
          pos_next = step;
        end
      end
      S_A_MARK: begin
        mem_we     = 1'b1;
        mem_wdata  = {rsz_q[15:2], MARK_BUSY};
        state_next = S_ST_START;
      end
      S_F_WALK: begin
        if (pos + 17'd4 == {1'b0, baddr_q}) begin
          if (mark != MARK_BUSY) begin
            status_q_next = ST_NOT_BUSY;
            state_next    = S_ST_START;
          end else begin
            mem_we        = 1'b1;
            mem_wdata     = {mem_rdata[15:2], MARK_FREE};
            status_q_next = ST_OK;
            changed_next  = 1'b1;
            state_next    = S_CO_START;
          end
        end else if (step_end) begin
          state_next = S_ST_START;
        end else begin
          pos_next = step;
        end
      end
      S_CO_START: begin
        rd_pos     = '0;
        pos_next   = '0;
        state_next = S_CO_HEAD;
      end
      S_CO_HEAD: begin
        hcur_next = mem_rdata;
        npos_next = step;
        if (step_end) begin
          state_next = S_ST_START;
        end else begin
          state_next = S_CO_WALK;
        end
      end
      S_CO_WALK: begin
        // hcur holds the header at pos, mem_rdata the header at npos.
        if (hcur[1:0] == MARK_FREE && mark == MARK_FREE) begin
          mem_we    = 1'b1;
          mem_wdata = {merged[15:2], MARK_FREE};
          hcur_next = {merged[15:2], MARK_FREE};
          npos_next = merge_step;
          rd_pos    = merge_step;
          if (merge_step >= pool_w) state_next = S_ST_START;
        end else begin
          pos_next  = npos;
          hcur_next = mem_rdata;
          npos_next = keep_step;
          rd_pos    = keep_step;
          if (keep_step >= pool_w) state_next = S_ST_START;
        end
      end
      S_ST_START: begin
        rd_pos     = '0;
        pos_next   = '0;
        state_next = S_ST_WALK;
      end
      S_ST_WALK: begin
        if (mark == MARK_FREE) begin
          nfree_next  = nfree + 13'd1;
          fbytes_next = fbytes + hsz[15:0];
          if (hsz[15:0] > largest) largest_next = hsz[15:0];
        end else begin
          nbusy_next = nbusy + 13'd1;
        end
        if (step_end) begin
          state_next = S_DONE;
        end else begin
          pos_next = step;
        end
      end
      S_DONE: begin
        if (out_free) begin
          res_load        = 1'b1;
          ll_mark_next    = ll_upd;
          lf_mark_next    = lf_upd;
          hb_mark_next    = hb_upd;
          hbusy_mark_next = hbusy_upd;
          if (cmd_q == CMD_REPORT) begin
            lreq_mark_next = LOW_MARK_INIT;
            hreq_mark_next = '0;
          end
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !mem_we)
    else $error("header write while idle");

  a_done_returns: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_free) |=> (state == S_IDLE))
    else $error("finished command did not return to idle");

  a_walk_in_pool: assert property (@(posedge clk) disable iff (rst)
    (state == S_A_WALK || state == S_F_WALK || state == S_ST_WALK || state == S_CO_WALK)
      |-> (pos < pool_w))
    else $error("walk position left the pool");

  a_load_only_done: assert property (@(posedge clk) disable iff (rst)
    res_load |-> (state == S_DONE))
    else $error("result loaded outside the done state");

endmodule

[hdl/first_fit_heap_allocator_core.sv]
`timescale 1ns / 1ps
// First-fit heap allocator: one command word in, one result word out.
// A finished command waits in S_DONE while the previous result word still holds the output
// register; each chain walk (search, merge, statistics) reads one header per cycle from the
// header RAM, and the chain holds at most POOL_WORDS headers.
// Throughput: one command at a time; the next is taken while the last result waits.
// Reset: synchronous; the S_INIT state writes the initial free header, no clearing pass.

module first_fit_heap_allocator_core import ffa_pkg::*; #(
  parameter int POOL_WORDS = 4096
) (
  input  logic      clk,
  input  logic      rst,
  ffa_req_if.sink   request,
  ffa_res_if.source result,
  ffa_cfg_if.sink   cfg
);

  localparam int WADDR      = $clog2(POOL_WORDS);
  localparam int TOP_BYTES  = 4 * POOL_WORDS;
  localparam int RESET_POOL = (TOP_BYTES < 16384) ? TOP_BYTES : 16384;

  logic [CFG_W-1:0] pool;
  logic [POS_W-1:0] cfg_clamped;
  logic             cfg_fire;

  logic             walk_we;
  logic [WADDR-1:0] walk_waddr, ram_waddr, ram_raddr;
  logic [HDR_W-1:0] walk_wdata, ram_wdata, ram_rdata;
  logic             ram_we;

  logic             res_load;
  res_t             res_word, res_q;
  logic             res_valid;

  // Configuration: round down to a word, saturate into [8, pool capacity].
  assign cfg.ready = 1'b1;
  assign cfg_fire  = cfg.valid && cfg.ready;

  always_comb begin
    cfg_clamped = {2'b00, cfg.pool_bytes & ~15'd3};
    if (cfg_clamped > 17'(TOP_BYTES)) cfg_clamped = 17'(TOP_BYTES);
    if (cfg_clamped < 17'd8) cfg_clamped = 17'd8;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pool <= CFG_W'(RESET_POOL);
    end else if (cfg_fire) begin
      pool <= cfg_clamped[CFG_W-1:0];
    end
  end

  // A configuration write re-makes the pool as one free block at word 0.
  always_comb begin
    if (cfg_fire) begin
      ram_we    = 1'b1;
      ram_waddr = '0;
      ram_wdata = 16'(cfg_clamped - 17'd4) | {14'd0, MARK_FREE};
    end else begin
      ram_we    = walk_we;
      ram_waddr = walk_waddr;
      ram_wdata = walk_wdata;
    end
  end

  ffa_hdr_ram #(
    .DEPTH (POOL_WORDS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ffa_walk #(
    .POOL_WORDS (POOL_WORDS)
  ) u_walk (
    .clk        (clk),
    .rst        (rst),
    .pool       (pool),
    .in_valid   (request.valid),
    .in_ready   (request.ready),
    .cmd        (request.cmd),
    .req_bytes  (request.req_bytes),
    .block_addr (request.block_addr),
    .out_free   (!res_valid || result.ready),
    .res_load   (res_load),
    .res        (res_word),
    .mem_we     (walk_we),
    .mem_waddr  (walk_waddr),
    .mem_wdata  (walk_wdata),
    .mem_raddr  (ram_raddr),
    .mem_rdata  (ram_rdata)
  );

  // Output register: hold the result word until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
    if (res_load) begin
      res_q <= res_word;
    end
  end

  assign result.valid            = res_valid;
  assign result.status           = res_q.status;
  assign result.addr             = res_q.addr;
  assign result.free_bytes       = res_q.free_bytes;
  assign result.largest_free     = res_q.largest_free;
  assign result.free_blocks      = res_q.free_blocks;
  assign result.busy_blocks      = res_q.busy_blocks;
  assign result.min_largest_free = res_q.min_largest_free;
  assign result.min_free_total   = res_q.min_free_total;
  assign result.peak_blocks      = res_q.peak_blocks;
  assign result.max_busy         = res_q.max_busy;
  assign result.min_request      = res_q.min_request;
  assign result.max_request      = res_q.max_request;

endmodule
